>>> rtl/als_pkg.sv
package als_pkg;

    localparam int QUOT_BITS = 15;
    localparam int CNT_W = 4;
    localparam int LEVEL_FRAC = 14;
    localparam int CONF_FRAC = 15;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int OUT_DATA_W = 72;

    localparam logic [15:0] LEVEL_MAX = 16'd24576;
    localparam logic [15:0] CONF_ONE = 16'd32768;
    localparam logic [13:0] QUARTER_Q15 = 14'd8192;

    localparam logic [1:0] REG_DC_RATE = 2'd0;
    localparam logic [1:0] REG_ATTACK_RATE = 2'd1;
    localparam logic [1:0] REG_RELEASE_RATE = 2'd2;
    localparam logic [1:0] REG_ENVELOPE_FLOOR = 2'd3;

    localparam logic [1:0] SYM_HIGH = 2'd0;
    localparam logic [1:0] SYM_MID_HIGH = 2'd1;
    localparam logic [1:0] SYM_MID_LOW = 2'd2;
    localparam logic [1:0] SYM_LOW = 2'd3;

    typedef struct packed {
        logic                 done;
        logic                 rem_nz;
        logic [QUOT_BITS-1:0] quot;
    } div_status_t;

endpackage

>>> rtl/als_div.sv
module als_div #(
    parameter int NUM_W = 47
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_W-1:0]      num,
    input  logic [NUM_W-1:0]      den,
    output als_pkg::div_status_t  status
);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [als_pkg::QUOT_BITS-1:0] quot_reg, quot_next;
    logic [als_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [NUM_W:0] trial;
    logic fits;

    assign trial = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign fits = ~trial[NUM_W];

    always_comb
    begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        quot_next = quot_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = num;
            dsh_next = den << (als_pkg::QUOT_BITS - 1);
            quot_next = '0;
            cnt_next = als_pkg::CNT_W'(als_pkg::QUOT_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = trial[NUM_W-1:0];
            end
            quot_next = {quot_reg[als_pkg::QUOT_BITS-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - als_pkg::CNT_W'(1);
            if (cnt_reg == als_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quot_reg <= quot_next;
    end

    assign status.done = done_reg;
    assign status.rem_nz = (rem_reg != '0);
    assign status.quot = quot_reg;

endmodule

>>> rtl/adaptive_level_slicer_top.sv
// The input is not ready while a sample is processed or while its result waits
// for the output to take it. The shared multiplier is used twice and the shared
// radix-2 divider runs 15 steps twice per sample.
// Reset: asynchronous, active low; registers take their defaults, the DC
// estimate clears and the envelope starts at the reset floor.
module adaptive_level_slicer_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // audio_sample in the low SAMPLE_BITS bits, zero padding above.
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // two_level_symbol, four_level_symbol, slice_level, signal_confidence,
    // dc_estimate, envelope_estimate, zero padding.
    output logic [als_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [als_pkg::PADDR_W-1:0]           paddr,
    input  logic [als_pkg::PDATA_W-1:0]           pwdata,
    output logic [als_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready
);

    localparam int ACC_W = SAMPLE_BITS + ACC_FRAC_BITS;
    localparam int OUT_SHIFT = ACC_W - 16;
    localparam int DIV_W = ACC_W + als_pkg::QUOT_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DC_LOAD,
        S_DC_MUL,
        S_DC_UPD,
        S_DIFF,
        S_ENV_LOAD,
        S_ENV_MUL,
        S_ENV_UPD,
        S_LVL_SET,
        S_LVL_DIV,
        S_CONF_DIV,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] dc_rate_reg, dc_rate_next;
    logic [15:0] attack_rate_reg, attack_rate_next;
    logic [15:0] release_rate_reg, release_rate_next;
    logic [12:0] floor_reg, floor_next;

    logic [ACC_W-1:0] x_reg, x_next;
    logic [ACC_W-1:0] dc_reg, dc_next;
    logic [ACC_W-1:0] env_reg, env_next;
    logic [ACC_W-1:0] mag_reg, mag_next;
    logic neg_reg, neg_next;
    logic sat_reg, sat_next;
    logic [1:0] four_reg, four_next;
    logic [15:0] level_reg, level_next;
    logic [15:0] conf_reg, conf_next;
    logic [ACC_W:0] mul_a_reg, mul_a_next;
    logic [15:0] mul_b_reg, mul_b_next;
    logic signed [ACC_W+17:0] prod_reg, prod_next;
    logic m_valid_reg, m_valid_next;
    logic [als_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic cfg_write;
    logic [12:0] floor_eff;
    logic [ACC_W-1:0] fl_acc;
    logic [ACC_W:0] x_minus_dc;
    logic [ACC_W:0] neg_x_minus_dc;
    logic [ACC_W:0] mag_minus_env;
    logic signed [ACC_W+17:0] mul_prod;
    logic [ACC_W+1:0] step;
    logic [ACC_W+1:0] dc_sum;
    logic [ACC_W+1:0] env_sum;
    logic [ACC_W+1:0] mag_x3;
    logic [ACC_W+1:0] env_x2;
    logic [15:0] lvl_q;
    logic [15:0] lvl_mag;
    logic div_start;
    logic [DIV_W-1:0] div_num;
    logic [DIV_W-1:0] div_den;
    als_pkg::div_status_t div_status;

    als_div #(
        .NUM_W(DIV_W)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .num(div_num),
        .den(div_den),
        .status(div_status)
    );

    assign cfg_write = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            als_pkg::REG_DC_RATE: prdata = {16'd0, dc_rate_reg};
            als_pkg::REG_ATTACK_RATE: prdata = {16'd0, attack_rate_reg};
            als_pkg::REG_RELEASE_RATE: prdata = {16'd0, release_rate_reg};
            als_pkg::REG_ENVELOPE_FLOOR: prdata = {19'd0, floor_reg};
            default: prdata = '0;
        endcase
    end

    assign floor_eff = (floor_reg == 13'd0) ? 13'd1 : floor_reg;
    assign fl_acc = ACC_W'(floor_eff) << OUT_SHIFT;

    assign x_minus_dc = {x_reg[ACC_W-1], x_reg} - {dc_reg[ACC_W-1], dc_reg};
    assign neg_x_minus_dc = -x_minus_dc;
    assign mag_minus_env = {1'b0, mag_reg} - {1'b0, env_reg};
    assign mul_prod = $signed({{17{mul_a_reg[ACC_W]}}, mul_a_reg})
                      * $signed({{(ACC_W + 1){1'b0}}, mul_b_reg});
    assign step = prod_reg[ACC_W+17:16];
    assign dc_sum = {{2{dc_reg[ACC_W-1]}}, dc_reg} + step;
    assign env_sum = {2'b00, env_reg} + step;
    assign mag_x3 = {1'b0, mag_reg, 1'b0} + {2'b00, mag_reg};
    assign env_x2 = {1'b0, env_reg, 1'b0};

    assign lvl_q = {1'b0, div_status.quot} + {15'd0, neg_reg & div_status.rem_nz};
    assign lvl_mag = (sat_reg || (lvl_q > als_pkg::LEVEL_MAX)) ? als_pkg::LEVEL_MAX : lvl_q;

    always_comb
    begin
        div_start = 1'b0;
        div_num = DIV_W'({mag_reg, {als_pkg::LEVEL_FRAC{1'b0}}});
        div_den = DIV_W'(env_reg);
        if (state_reg == S_LVL_SET)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == S_LVL_DIV)
        begin
            div_start = div_status.done;
            div_num = DIV_W'({env_reg - fl_acc, {als_pkg::CONF_FRAC{1'b0}}});
            div_den = DIV_W'({1'b0, als_pkg::QUARTER_Q15 - {1'b0, floor_eff}}) << OUT_SHIFT;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dc_rate_next = dc_rate_reg;
        attack_rate_next = attack_rate_reg;
        release_rate_next = release_rate_reg;
        floor_next = floor_reg;
        x_next = x_reg;
        dc_next = dc_reg;
        env_next = env_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        sat_next = sat_reg;
        four_next = four_reg;
        level_next = level_reg;
        conf_next = conf_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        prod_next = prod_reg;
        out_data_next = out_data_reg;
        m_valid_next = m_valid_reg & ~m_axis_tready;

        if (cfg_write)
        begin
            case (paddr[3:2])
                als_pkg::REG_DC_RATE: dc_rate_next = pwdata[15:0];
                als_pkg::REG_ATTACK_RATE: attack_rate_next = pwdata[15:0];
                als_pkg::REG_RELEASE_RATE: release_rate_next = pwdata[15:0];
                als_pkg::REG_ENVELOPE_FLOOR: floor_next = pwdata[12:0];
                default: floor_next = floor_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    x_next = {s_axis_tdata[SAMPLE_BITS-1:0], {ACC_FRAC_BITS{1'b0}}};
                    state_next = S_DC_LOAD;
                end
            end
            S_DC_LOAD:
            begin
                mul_a_next = x_minus_dc;
                mul_b_next = dc_rate_reg;
                state_next = S_DC_MUL;
            end
            S_DC_MUL:
            begin
                prod_next = mul_prod;
                state_next = S_DC_UPD;
            end
            S_DC_UPD:
            begin
                dc_next = dc_sum[ACC_W-1:0];
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                neg_next = x_minus_dc[ACC_W];
                mag_next = x_minus_dc[ACC_W] ? neg_x_minus_dc[ACC_W-1:0]
                                             : x_minus_dc[ACC_W-1:0];
                state_next = S_ENV_LOAD;
            end
            S_ENV_LOAD:
            begin
                mul_a_next = mag_minus_env;
                mul_b_next = (!mag_minus_env[ACC_W] && (mag_minus_env != '0))
                             ? attack_rate_reg : release_rate_reg;
                state_next = S_ENV_MUL;
            end
            S_ENV_MUL:
            begin
                prod_next = mul_prod;
                state_next = S_ENV_UPD;
            end
            S_ENV_UPD:
            begin
                env_next = (env_sum[ACC_W-1:0] < fl_acc) ? fl_acc : env_sum[ACC_W-1:0];
                state_next = S_LVL_SET;
            end
            S_LVL_SET:
            begin
                sat_next = ({2'b00, mag_reg} >= env_x2);
                if (!neg_reg)
                begin
                    four_next = (mag_x3 >= env_x2) ? als_pkg::SYM_HIGH
                                                   : als_pkg::SYM_MID_HIGH;
                end
                else
                begin
                    four_next = (mag_x3 <= env_x2) ? als_pkg::SYM_MID_LOW
                                                   : als_pkg::SYM_LOW;
                end
                state_next = S_LVL_DIV;
            end
            S_LVL_DIV:
            begin
                if (div_status.done)
                begin
                    level_next = neg_reg ? (16'd0 - lvl_mag) : lvl_mag;
                    state_next = S_CONF_DIV;
                end
            end
            S_CONF_DIV:
            begin
                if (div_status.done)
                begin
                    conf_next = (env_reg[ACC_W-1 -: 3] != 3'd0) ? als_pkg::CONF_ONE
                                                                : {1'b0, div_status.quot};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_data_next = {4'd0,
                                     env_reg[ACC_W-1 -: 16],
                                     dc_reg[ACC_W-1 -: 16],
                                     conf_reg,
                                     level_reg,
                                     four_reg,
                                     neg_reg ? als_pkg::SYM_LOW : als_pkg::SYM_HIGH};
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dc_rate_reg <= 16'd66;
            attack_rate_reg <= 16'd5243;
            release_rate_reg <= 16'd66;
            floor_reg <= 13'd655;
            x_reg <= '0;
            dc_reg <= '0;
            env_reg <= ACC_W'(13'd655) << OUT_SHIFT;
            mag_reg <= '0;
            neg_reg <= 1'b0;
            sat_reg <= 1'b0;
            four_reg <= als_pkg::SYM_HIGH;
            level_reg <= '0;
            conf_reg <= '0;
            mul_a_reg <= '0;
            mul_b_reg <= '0;
            prod_reg <= '0;
            m_valid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dc_rate_reg <= dc_rate_next;
            attack_rate_reg <= attack_rate_next;
            release_rate_reg <= release_rate_next;
            floor_reg <= floor_next;
            x_reg <= x_next;
            dc_reg <= dc_next;
            env_reg <= env_next;
            mag_reg <= mag_next;
            neg_reg <= neg_next;
            sat_reg <= sat_next;
            four_reg <= four_next;
            level_reg <= level_next;
            conf_reg <= conf_next;
            mul_a_reg <= mul_a_next;
            mul_b_reg <= mul_b_next;
            prod_reg <= prod_next;
            m_valid_reg <= m_valid_next;
            out_data_reg <= out_data_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = out_data_reg;

endmodule

>>> tb/tb_adaptive_level_slicer_top.sv
`timescale 1ns / 100ps

module tb_adaptive_level_slicer_top;

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [15:0] DEF_DC_RATE = 16'd66;
    localparam logic [15:0] DEF_ATTACK_RATE = 16'd5243;
    localparam logic [15:0] DEF_RELEASE_RATE = 16'd66;
    localparam logic [12:0] DEF_ENVELOPE_FLOOR = 13'd655;

    typedef struct {
        logic [1:0]  two_sym;
        logic [1:0]  four_sym;
        logic [15:0] level;
        logic [15:0] conf;
        logic [15:0] dc;
        logic [15:0] env;
    } slicer_word_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [als_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [als_pkg::PADDR_W-1:0]    paddr;
    logic [als_pkg::PDATA_W-1:0]    pwdata;
    logic [als_pkg::PDATA_W-1:0]    prdata;
    logic                           pready;

    logic [15:0] cfg_dc_rate;
    logic [15:0] cfg_attack_rate;
    logic [15:0] cfg_release_rate;
    logic [12:0] cfg_floor;
    longint      dc_acc;
    longint      env_acc;

    slicer_word_t pending_words[$];
    slicer_word_t oldest;
    int           error_count = 0;
    bit           tx_idle = 1'b1;
    bit           rx_idle = 1'b1;
    bit           rx_hold = 1'b0;
    int           fsk_amp = 12000;
    int           fsk_dc = 0;

    adaptive_level_slicer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_adaptive_level_slicer_top: errors");
        $finish;
    end

    function automatic longint floor_acc();
        return longint'(cfg_floor == 13'd0 ? 13'd1 : cfg_floor) * 65536;
    endfunction

    function automatic longint rate_move(input longint d, input logic [15:0] r);
        return (d * longint'(r)) >>> 16;
    endfunction

    // Advances the DC and envelope trackers by one sample and returns the sliced word.
    function automatic slicer_word_t slice_sample(input logic signed [15:0] sample);
        slicer_word_t w;
        longint       x;
        longint       diff;
        longint       mag;
        longint       fl;
        longint       level;
        longint       conf;
        longint       quarter;
        logic [15:0]  r;

        x = longint'(sample) * 65536;
        dc_acc = dc_acc + rate_move(x - dc_acc, cfg_dc_rate);
        diff = x - dc_acc;
        mag = diff < 0 ? -diff : diff;
        r = mag > env_acc ? cfg_attack_rate : cfg_release_rate;
        env_acc = env_acc + rate_move(mag - env_acc, r);
        fl = floor_acc();
        if (env_acc < fl)
            env_acc = fl;

        if (diff >= 0)
            level = (diff * 16384) / env_acc;
        else
            level = -(((-diff) * 16384 + env_acc - 1) / env_acc);
        if (level > longint'(als_pkg::LEVEL_MAX))
            level = longint'(als_pkg::LEVEL_MAX);
        if (level < -longint'(als_pkg::LEVEL_MAX))
            level = -longint'(als_pkg::LEVEL_MAX);

        if (3 * diff >= 2 * env_acc)
            w.four_sym = als_pkg::SYM_HIGH;
        else if (diff >= 0)
            w.four_sym = als_pkg::SYM_MID_HIGH;
        else if (3 * diff >= -2 * env_acc)
            w.four_sym = als_pkg::SYM_MID_LOW;
        else
            w.four_sym = als_pkg::SYM_LOW;

        quarter = longint'(1) << 29;
        if (env_acc >= quarter)
            conf = longint'(als_pkg::CONF_ONE);
        else if (quarter <= fl)
            conf = 0;
        else
            conf = ((env_acc - fl) * longint'(als_pkg::CONF_ONE)) / (quarter - fl);
        if (conf < 0)
            conf = 0;
        if (conf > longint'(als_pkg::CONF_ONE))
            conf = longint'(als_pkg::CONF_ONE);

        w.two_sym = diff >= 0 ? als_pkg::SYM_HIGH : als_pkg::SYM_LOW;
        w.level = level[15:0];
        w.conf = conf[15:0];
        w.dc = 16'(dc_acc >>> 16);
        w.env = 16'(env_acc >> 16);
        return w;
    endfunction

    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        case (idx)
            als_pkg::REG_DC_RATE:      return {16'd0, cfg_dc_rate};
            als_pkg::REG_ATTACK_RATE:  return {16'd0, cfg_attack_rate};
            als_pkg::REG_RELEASE_RATE: return {16'd0, cfg_release_rate};
            default:                   return {19'd0, cfg_floor};
        endcase
    endfunction

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(1, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [12:0] pick_floor();
        case ($urandom_range(0, 4))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'h1FFF;
            default: return 13'($urandom_range(1, 8191));
        endcase
    endfunction

    // Mostly four-level FSK symbols around a DC offset, with some noise and raw values.
    function automatic logic [15:0] next_sample();
        int v;
        int lvl;
        int spread;

        case ($urandom_range(0, 9))
            0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
            3:       v = $urandom_range(0, 1) ? 32767 : -32768;
            4:       v = int'($urandom_range(0, 128)) - 64;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       lvl = 3;
                    1:       lvl = 1;
                    2:       lvl = -1;
                    default: lvl = -3;
                endcase
                spread = fsk_amp / 16 + 1;
                v = fsk_dc + (fsk_amp * lvl) / 3 + int'($urandom_range(0, 2 * spread)) - spread;
            end
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    task automatic apb_access(input logic write, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = write;
        paddr = {idx, 2'b00};
        pwdata = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] rd;

        apb_access(1'b0, idx, 32'd0, rd);
        if (rd !== reg_value(idx))
        begin
            $display("%0t: register %0d expected %0d actual %0d", $time, idx,
                     reg_value(idx), rd);
            error_count++;
        end
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;

        apb_access(1'b1, idx, value, rd);
        case (idx)
            als_pkg::REG_DC_RATE:      cfg_dc_rate = value[15:0];
            als_pkg::REG_ATTACK_RATE:  cfg_attack_rate = value[15:0];
            als_pkg::REG_RELEASE_RATE: cfg_release_rate = value[15:0];
            default:                   cfg_floor = value[12:0];
        endcase
        check_reg(idx);
    endtask

    task automatic set_all(input logic [15:0] dc_r, input logic [15:0] att_r,
                           input logic [15:0] rel_r, input logic [12:0] flr);
        set_reg(als_pkg::REG_DC_RATE, {16'($urandom), dc_r});
        set_reg(als_pkg::REG_ATTACK_RATE, {16'($urandom), att_r});
        set_reg(als_pkg::REG_RELEASE_RATE, {16'($urandom), rel_r});
        set_reg(als_pkg::REG_ENVELOPE_FLOOR, {19'($urandom), flr});
    endtask

    task automatic send_sample(input logic [15:0] sample);
        @(negedge clk);
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = sample;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_words.push_back(slice_sample(sample));
    endtask

    task automatic stop_and_drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic test_register_defaults();
        check_reg(als_pkg::REG_DC_RATE);
        check_reg(als_pkg::REG_ATTACK_RATE);
        check_reg(als_pkg::REG_RELEASE_RATE);
        check_reg(als_pkg::REG_ENVELOPE_FLOOR);
    endtask

    task automatic test_directed_extremes();
        send_sample(16'sd0);
        send_sample(16'sd32767);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(-16'sd32768);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        stop_and_drain();

        set_all(16'd0, 16'hFFFF, 16'hFFFF, 13'h1FFF);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        stop_and_drain();

        // A zero floor must behave as the smallest nonzero floor.
        set_all(16'hFFFF, 16'd0, 16'd0, 13'd0);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd5);
        send_sample(16'sd0);
        stop_and_drain();

        // Raising the floor lifts the frozen envelope when the next sample is processed.
        set_reg(als_pkg::REG_ENVELOPE_FLOOR, 32'h1FFF);
        send_sample(16'sd1000);
        send_sample(-16'sd1000);
        stop_and_drain();

        set_reg(als_pkg::REG_ENVELOPE_FLOOR, 32'd1);
        set_reg(als_pkg::REG_RELEASE_RATE, 32'hFFFF);
        send_sample(16'sd0);
        send_sample(16'sd0);
        stop_and_drain();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 5; phase++)
        begin
            set_all(pick_rate(), pick_rate(), pick_rate(), pick_floor());
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            fsk_amp = $urandom_range(200, 30000);
            fsk_dc = int'($urandom_range(0, 8000)) - 4000;
            repeat (85) send_sample(next_sample());
            stop_and_drain();
        end
    endtask

    task automatic test_backpressure();
        set_all(DEF_DC_RATE, DEF_ATTACK_RATE, DEF_RELEASE_RATE, DEF_ENVELOPE_FLOOR);
        tx_idle = 1'b0;
        rx_hold = 1'b1;
        repeat (12) send_sample(next_sample());
        stop_and_drain();
    endtask

    task automatic test_steady_stream();
        set_all(16'($urandom_range(1, 2000)), 16'($urandom_range(1000, 20000)),
                16'($urandom_range(1, 2000)), 13'($urandom_range(1, 2000)));
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        fsk_amp = $urandom_range(4000, 20000);
        fsk_dc = int'($urandom_range(0, 4000)) - 2000;
        repeat (100) send_sample(next_sample());
        stop_and_drain();
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold = 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: result word expected none actual %h", $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                oldest = pending_words.pop_front();
                check_field("two_level_symbol", {14'd0, oldest.two_sym},
                            {14'd0, m_axis_tdata[1:0]});
                check_field("four_level_symbol", {14'd0, oldest.four_sym},
                            {14'd0, m_axis_tdata[3:2]});
                check_field("slice_level", oldest.level, m_axis_tdata[19:4]);
                check_field("signal_confidence", oldest.conf, m_axis_tdata[35:20]);
                check_field("dc_estimate", oldest.dc, m_axis_tdata[51:36]);
                check_field("envelope_estimate", oldest.env, m_axis_tdata[67:52]);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 16'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_dc_rate = DEF_DC_RATE;
        cfg_attack_rate = DEF_ATTACK_RATE;
        cfg_release_rate = DEF_RELEASE_RATE;
        cfg_floor = DEF_ENVELOPE_FLOOR;
        dc_acc = 0;
        env_acc = floor_acc();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_defaults();
        test_directed_extremes();
        test_random_settings();
        test_backpressure();
        test_steady_stream();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_adaptive_level_slicer_top: clean");
        else
            $display("tb_adaptive_level_slicer_top: errors");
        $finish;
    end

endmodule
